@@ sv/xwt_pkg.sv @@
package xwt_pkg;

  // Fixed geometry of the scanner
  localparam int LOOKBACK_DEPTH = 7;
  localparam int LB_VALID_W     = $clog2(LOOKBACK_DEPTH + 1);
  localparam int LB_IDX_W       = $clog2(LOOKBACK_DEPTH);
  localparam int NUM_DELIM_REGS = 4;
  localparam int MAX_DELIMS     = 4;
  localparam int DELIM_LIMIT    = (MAX_DELIMS < NUM_DELIM_REGS) ? MAX_DELIMS : NUM_DELIM_REGS;
  localparam int COUNT_BITS_DEF = 16;
  localparam int RES_FIFO_DEPTH = 4;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_WORD_LEN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_A      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_B      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_C      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_D      = 3'd5;

  // Character codes
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_DEL   = 8'd127;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3B;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_SKIP = 3'b010,
    PH_WORD = 3'b100
  } phase_t;

  // Newest consumed byte at index 0
  typedef logic [LOOKBACK_DEPTH-1:0][7:0] lb_t;

  typedef struct packed {
    logic [7:0]                       max_word_len;
    logic [2:0]                       delim_count;
    logic [NUM_DELIM_REGS-1:0][7:0]   delim;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        is_word_end;
    logic [15:0] consumed_count;
    logic [8:0]  word_length;
    logic        overflow;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } scan_out_t;

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dec(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

  // Separators that are consumed but never join the word
  function automatic logic is_sep2(input logic [7:0] c);
    logic r;
    case (c)
      8'd33, 8'd34, 8'd39, 8'd40, 8'd41, 8'd43, 8'd44, 8'd46,
      8'd47, 8'd58, 8'd60, 8'd61, 8'd62, 8'd63, 8'd64, 8'd91,
      8'd92, 8'd93, 8'd94, 8'd96, 8'd123, 8'd124, 8'd125, 8'd126: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic res_t mk_byte(input logic [7:0] b);
    res_t r;
    r = '0;
    r.out_byte = b;
    return r;
  endfunction

  function automatic res_t mk_sum(input logic [15:0] cnt, input logic [8:0] wl,
                                  input logic ovf);
    res_t r;
    r = '0;
    r.is_word_end    = 1'b1;
    r.consumed_count = cnt;
    r.word_length    = wl;
    r.overflow       = ovf;
    return r;
  endfunction

endpackage

@@ sv/xwt_entity.sv @@
module xwt_entity (
  input  xwt_pkg::lb_t                          recent,
  input  logic [xwt_pkg::LB_VALID_W-1:0]        rvalid,
  output logic                                  ok
);

  // Entity test for an '&' that lies d bytes before the ';'
  function automatic logic ent_ok_at(input int d, input xwt_pkg::lb_t r);
    logic hexall;
    logic decall;
    logic res;
    int   i_hash;
    int   i_kind;
    hexall = 1'b1;
    decall = 1'b1;
    res    = 1'b0;
    i_hash = (d >= 3) ? d - 2 : 0;
    i_kind = (d >= 3) ? d - 3 : 0;
    for (int i = 0; i < xwt_pkg::LOOKBACK_DEPTH; i++) begin
      if (i + 4 <= d) begin
        if (!xwt_pkg::is_hex(r[i])) hexall = 1'b0;
        if (!xwt_pkg::is_dec(r[i])) decall = 1'b0;
      end
    end
    if (d == 5 && r[3] == "q" && r[2] == "u" && r[1] == "o" && r[0] == "t") begin
      res = 1'b1;
    end else if (d == 5 && r[3] == "a" && r[2] == "p" && r[1] == "o" && r[0] == "s") begin
      res = 1'b1;
    end else if (d == 3 && (r[1] == "l" || r[1] == "g") && r[0] == "t") begin
      res = 1'b1;
    end else if (d == 4 && r[2] == "a" && r[1] == "m" && r[0] == "p") begin
      res = 1'b1;
    end else if (d >= 3 && r[i_hash] == "#") begin
      if (r[i_kind] == "x") begin
        res = hexall;
      end else if (xwt_pkg::is_dec(r[i_kind])) begin
        res = decall;
      end
    end
    return res;
  endfunction

  logic [xwt_pkg::LOOKBACK_DEPTH-1:0] ok_vec;
  logic [xwt_pkg::LB_IDX_W-1:0]       sel;
  logic                               found;

  always_comb begin
    for (int k = 0; k < xwt_pkg::LOOKBACK_DEPTH; k++) begin
      ok_vec[k] = ent_ok_at(k + 1, recent);
    end
  end

  // Nearest '&' among the valid entries wins
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int k = xwt_pkg::LOOKBACK_DEPTH - 1; k >= 0; k--) begin
      if ((xwt_pkg::LB_VALID_W'(k) < rvalid) && recent[k] == xwt_pkg::CH_AMP) begin
        found = 1'b1;
        sel   = xwt_pkg::LB_IDX_W'(k);
      end
    end
    ok = found && ok_vec[sel];
  end

endmodule

@@ sv/xwt_scan.sv @@
module xwt_scan #(
  parameter int COUNT_BITS = xwt_pkg::COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_acc,
  input  logic [7:0]          data_byte,
  input  logic                scan_start,
  input  logic                data_end,
  input  xwt_pkg::cfg_t       cfg,
  output xwt_pkg::scan_out_t  so
);

  xwt_pkg::phase_t                    phase_r, phase_nxt, phase_e;
  xwt_pkg::lb_t                       recent_r, recent_nxt, recent_sh;
  logic [xwt_pkg::LB_VALID_W-1:0]     rvalid_r, rvalid_nxt, rv_e, rv_inc;
  logic [8:0]                         wc_r, wc_nxt, wc_e, wc_inc;
  logic [COUNT_BITS-1:0]              bc_r, bc_nxt, bc_e, bc_inc;
  logic [COUNT_BITS+15:0]             bc_e_ext, bc_inc_ext;
  logic [15:0]                        cnt_e, cnt_inc;
  logic [2:0]                         nd;
  logic                               dhit;
  logic                               ent_ok;
  logic                               do_word;

  // Scan start wipes the per-scan state before this byte is looked at
  always_comb begin
    phase_e   = scan_start ? xwt_pkg::PH_SKIP : phase_r;
    rv_e      = scan_start ? '0 : rvalid_r;
    wc_e      = scan_start ? '0 : wc_r;
    bc_e      = scan_start ? '0 : bc_r;
    recent_sh = {recent_r[xwt_pkg::LOOKBACK_DEPTH-2:0], data_byte};
    rv_inc    = (rv_e == xwt_pkg::LB_VALID_W'(xwt_pkg::LOOKBACK_DEPTH)) ? rv_e :
                xwt_pkg::LB_VALID_W'(rv_e + 1'b1);
    bc_inc    = (bc_e == {COUNT_BITS{1'b1}}) ? bc_e : COUNT_BITS'(bc_e + 1'b1);
    wc_inc    = 9'(wc_e + 9'd1);
    bc_e_ext   = {16'b0, bc_e};
    bc_inc_ext = {16'b0, bc_inc};
    cnt_e      = bc_e_ext[15:0];
    cnt_inc    = bc_inc_ext[15:0];
  end

  always_comb begin
    nd = (cfg.delim_count > 3'(xwt_pkg::DELIM_LIMIT)) ? 3'(xwt_pkg::DELIM_LIMIT) :
         cfg.delim_count;
    dhit = 1'b0;
    for (int i = 0; i < xwt_pkg::NUM_DELIM_REGS; i++) begin
      if ((3'(i) < nd) && data_byte == cfg.delim[i]) dhit = 1'b1;
    end
  end

  xwt_entity u_entity (
    .recent (recent_r),
    .rvalid (rv_e),
    .ok     (ent_ok)
  );

  always_comb begin
    phase_nxt  = phase_r;
    recent_nxt = recent_r;
    rvalid_nxt = rvalid_r;
    wc_nxt     = wc_r;
    bc_nxt     = bc_r;
    so         = '0;
    do_word    = 1'b0;
    if (item_acc) begin
      phase_nxt  = phase_e;
      rvalid_nxt = rv_e;
      wc_nxt     = wc_e;
      bc_nxt     = bc_e;
      case (phase_e)
        xwt_pkg::PH_IDLE: begin
        end
        xwt_pkg::PH_SKIP: begin
          if (data_byte <= xwt_pkg::CH_SPACE) begin
            recent_nxt = recent_sh;
            rvalid_nxt = rv_inc;
            bc_nxt     = bc_inc;
            if (data_end) begin
              so.n      = 2'd1;
              so.r0     = xwt_pkg::mk_sum('0, '0, 1'b0);
              phase_nxt = xwt_pkg::PH_IDLE;
            end
          end else begin
            do_word = 1'b1;
          end
        end
        xwt_pkg::PH_WORD: do_word = 1'b1;
        default: phase_nxt = xwt_pkg::PH_IDLE;
      endcase

      if (do_word) begin
        phase_nxt = xwt_pkg::PH_IDLE;
        if (data_byte <= xwt_pkg::CH_SPACE || data_byte == xwt_pkg::CH_DEL || dhit) begin
          so.n  = 2'd1;
          so.r0 = xwt_pkg::mk_sum(cnt_e, wc_e, 1'b0);
        end else if (xwt_pkg::is_sep2(data_byte)) begin
          recent_nxt = recent_sh;
          rvalid_nxt = rv_inc;
          bc_nxt     = bc_inc;
          so.n       = 2'd1;
          so.r0      = xwt_pkg::mk_sum(cnt_inc, wc_e, 1'b0);
        end else if (data_byte == xwt_pkg::CH_SEMI) begin
          recent_nxt = recent_sh;
          rvalid_nxt = rv_inc;
          bc_nxt     = bc_inc;
          if (ent_ok) begin
            wc_nxt = wc_inc;
            so.n   = 2'd2;
            so.r0  = xwt_pkg::mk_byte(xwt_pkg::CH_SEMI);
            so.r1  = xwt_pkg::mk_sum(cnt_inc, wc_inc, 1'b0);
          end else begin
            so.n   = 2'd1;
            so.r0  = xwt_pkg::mk_sum(cnt_inc, wc_e, 1'b0);
          end
        end else if (wc_e >= {1'b0, cfg.max_word_len}) begin
          so.n  = 2'd1;
          so.r0 = xwt_pkg::mk_sum('0, wc_e, 1'b1);
        end else begin
          recent_nxt = recent_sh;
          rvalid_nxt = rv_inc;
          bc_nxt     = bc_inc;
          wc_nxt     = wc_inc;
          so.r0      = xwt_pkg::mk_byte(data_byte);
          if (data_end) begin
            so.n  = 2'd2;
            so.r1 = xwt_pkg::mk_sum(cnt_inc, wc_inc, 1'b0);
          end else begin
            so.n      = 2'd1;
            phase_nxt = xwt_pkg::PH_WORD;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= xwt_pkg::PH_IDLE;
      rvalid_r <= '0;
      wc_r     <= '0;
      bc_r     <= '0;
    end else begin
      phase_r  <= phase_nxt;
      rvalid_r <= rvalid_nxt;
      wc_r     <= wc_nxt;
      bc_r     <= bc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    recent_r <= recent_nxt;
  end

endmodule

@@ sv/xwt_res_fifo.sv @@
module xwt_res_fifo #(
  parameter int DEPTH = xwt_pkg::RES_FIFO_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         push_n,
  input  xwt_pkg::res_t      wr0,
  input  xwt_pkg::res_t      wr1,
  input  logic               pop,
  output xwt_pkg::res_t      head,
  output logic               not_empty,
  output logic               room2
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  xwt_pkg::res_t     mem [DEPTH];
  logic [PTR_W-1:0]  wp_r, wp_nxt, wp1, rp_r, rp_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  always_comb begin
    wp1       = ptr_inc(wp_r);
    wp_nxt    = (push_n == 2'd2) ? ptr_inc(wp1) : (push_n == 2'd1) ? wp1 : wp_r;
    rp_nxt    = pop ? ptr_inc(rp_r) : rp_r;
    cnt_nxt   = CNT_W'(cnt_r + CNT_W'(push_n) - CNT_W'(pop));
    head      = mem[rp_r];
    not_empty = (cnt_r != '0);
    room2     = (cnt_r <= CNT_W'(DEPTH - 2));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem[wp_r] <= wr0;
    if (push_n == 2'd2) mem[wp1]  <= wr1;
  end

endmodule

@@ sv/xml_word_tokenizer_top.sv @@
// XML word tokenizer: scans one word per scan, one text byte per word handshake.
// Input channel (in_valid/in_stall): a word carries in_data_byte, in_scan_start
// (first byte of a new scan, aborts any open scan) and in_data_end (last byte).
// Result channel (out_valid/out_stall): each byte placed in the word comes out as
// a byte result; each scan closes with one summary (out_is_word_end high) that
// carries consumed bytes, word length and the overflow flag.
// Configuration (cfg_wr_en/cfg_index/cfg_wdata): write max_word_len, delim_count
// and the four extra delimiters only while the block is idle.
// Results of a byte are written to the result queue when it is accepted. Throughput:
// one byte per cycle while in_stall is low; the scan state update is a single
// level of logic between the state registers and a four-entry result queue.
// A byte that ends a word on an entity ';' or on in_data_end yields two results:
// a byte result and then the summary.
// Stall: the receiver may stall at will; the queue absorbs it and in_stall rises
// once fewer than two entries are free, so no result is ever dropped.
// Reset (rst_n low, synchronous): no scan is open, the queue is empty, and the
// registers return to max_word_len 255, no delimiters.
module xml_word_tokenizer_top #(
  parameter int COUNT_BITS = xwt_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_data_byte,
  input  logic                              in_scan_start,
  input  logic                              in_data_end,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        out_byte,
  output logic                              out_is_word_end,
  output logic [15:0]                       out_consumed_count,
  output logic [8:0]                        out_word_length,
  output logic                              out_overflow,
  // configuration
  input  logic                              cfg_wr_en,
  input  logic [xwt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [xwt_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  xwt_pkg::cfg_t       cfg_r, cfg_nxt;
  xwt_pkg::scan_out_t  scan_o;
  xwt_pkg::res_t       head;
  logic                item_acc;
  logic                pop;
  logic                room2;
  logic [1:0]          push_n;

  // Configuration writes; indexes past the list are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        xwt_pkg::REG_MAX_WORD_LEN: cfg_nxt.max_word_len = cfg_wdata;
        xwt_pkg::REG_DELIM_COUNT:  cfg_nxt.delim_count  = cfg_wdata[2:0];
        xwt_pkg::REG_DELIM_A:      cfg_nxt.delim[0]     = cfg_wdata;
        xwt_pkg::REG_DELIM_B:      cfg_nxt.delim[1]     = cfg_wdata;
        xwt_pkg::REG_DELIM_C:      cfg_nxt.delim[2]     = cfg_wdata;
        xwt_pkg::REG_DELIM_D:      cfg_nxt.delim[3]     = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{max_word_len: 8'd255, delim_count: 3'd0, delim: '0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Accept a word only when the queue can take both results it may cause
  assign in_stall = !room2;
  assign item_acc = in_valid && !in_stall;
  assign push_n   = item_acc ? scan_o.n : 2'd0;

  xwt_scan #(
    .COUNT_BITS (COUNT_BITS)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_acc   (item_acc),
    .data_byte  (in_data_byte),
    .scan_start (in_scan_start),
    .data_end   (in_data_end),
    .cfg        (cfg_r),
    .so         (scan_o)
  );

  // Results queue up in order; the head drives the result ports
  xwt_res_fifo #(
    .DEPTH (xwt_pkg::RES_FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .wr0       (scan_o.r0),
    .wr1       (scan_o.r1),
    .pop       (pop),
    .head      (head),
    .not_empty (out_valid),
    .room2     (room2)
  );

  assign pop                = out_valid && !out_stall;
  assign out_byte           = head.out_byte;
  assign out_is_word_end    = head.is_word_end;
  assign out_consumed_count = head.consumed_count;
  assign out_word_length    = head.word_length;
  assign out_overflow       = head.overflow;

  // A byte result never carries summary fields
  a_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_word_end) |->
      (out_consumed_count == 16'd0 && out_word_length == 9'd0 && !out_overflow))
    else $error("byte result carries summary fields");

  // An overflow summary reports no consumed bytes
  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |-> (out_is_word_end && out_consumed_count == 16'd0))
    else $error("overflow summary with nonzero count");

  // When a word yields two results, the second closes the scan
  a_pair_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (item_acc && scan_o.n == 2'd2) |-> (scan_o.r1.is_word_end && !scan_o.r0.is_word_end))
    else $error("two-result word does not end in a summary");

  // Word length never passes the 256 that a trailing entity ';' allows
  a_wl_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word_length <= 9'd256))
    else $error("word length out of range");

endmodule

@@ dv/xml_word_tokenizer_top_tb.sv @@
// Tracks scan state and register settings and keeps the results that each
// accepted byte is due to produce, oldest first.
class word_tracker;
  // register copies
  logic [7:0] max_len;
  logic [2:0] n_delims;
  logic [7:0] delim [xwt_pkg::NUM_DELIM_REGS];

  // scan state
  xwt_pkg::phase_t phase;
  logic [7:0] hist [xwt_pkg::LOOKBACK_DEPTH];  // newest consumed byte at index 0
  int         hist_n;
  int         tok_len;
  int         consumed;

  xwt_pkg::res_t due_results [$];
  int         errors;

  function new();
    int i;
    max_len  = 8'd255;
    n_delims = 3'd0;
    for (i = 0; i < xwt_pkg::NUM_DELIM_REGS; i++) delim[i] = 8'd0;
    phase    = xwt_pkg::PH_IDLE;
    hist_n   = 0;
    tok_len  = 0;
    consumed = 0;
    errors   = 0;
  endfunction

  function void write_reg(logic [xwt_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
    case (idx)
      xwt_pkg::REG_MAX_WORD_LEN: max_len  = val;
      xwt_pkg::REG_DELIM_COUNT:  n_delims = val[2:0];
      xwt_pkg::REG_DELIM_A:      delim[0] = val;
      xwt_pkg::REG_DELIM_B:      delim[1] = val;
      xwt_pkg::REG_DELIM_C:      delim[2] = val;
      xwt_pkg::REG_DELIM_D:      delim[3] = val;
      default: ;
    endcase
  endfunction

  function bit is_punct(logic [7:0] c);
    case (c)
      8'd33, 8'd34, 8'd39, 8'd40, 8'd41, 8'd43, 8'd44, 8'd46,
      8'd47, 8'd58, 8'd60, 8'd61, 8'd62, 8'd63, 8'd64, 8'd91,
      8'd92, 8'd93, 8'd94, 8'd96, 8'd123, 8'd124, 8'd125, 8'd126: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function bit dec_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function bit hex_digit(logic [7:0] c);
    return dec_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function int active_delims();
    return (n_delims > xwt_pkg::DELIM_LIMIT) ? xwt_pkg::DELIM_LIMIT : int'(n_delims);
  endfunction

  // byte j places after the '&' that lies d bytes back
  function logic [7:0] amp_rel(int d, int j);
    return hist[d - 1 - j];
  endfunction

  // true when the bytes before a ';' spell a known or numeric entity
  function bit entity_before_semi();
    int d, k, j;
    bit ok;
    d = 0;
    for (k = (hist_n < xwt_pkg::LOOKBACK_DEPTH) ? hist_n : xwt_pkg::LOOKBACK_DEPTH;
         k >= 1; k--)
      if (hist[k-1] == xwt_pkg::CH_AMP) d = k;
    if (d == 0) return 1'b0;
    if (d == 5 && amp_rel(d, 1) == "q" && amp_rel(d, 2) == "u" &&
        amp_rel(d, 3) == "o" && amp_rel(d, 4) == "t") return 1'b1;
    if (d == 5 && amp_rel(d, 1) == "a" && amp_rel(d, 2) == "p" &&
        amp_rel(d, 3) == "o" && amp_rel(d, 4) == "s") return 1'b1;
    if (d == 3 && (amp_rel(d, 1) == "l" || amp_rel(d, 1) == "g") &&
        amp_rel(d, 2) == "t") return 1'b1;
    if (d == 4 && amp_rel(d, 1) == "a" && amp_rel(d, 2) == "m" &&
        amp_rel(d, 3) == "p") return 1'b1;
    if (d < 3 || amp_rel(d, 1) != "#") return 1'b0;
    if (amp_rel(d, 2) == "x") begin
      ok = 1'b1;
      for (j = 3; j < d; j++) if (!hex_digit(amp_rel(d, j))) ok = 1'b0;
      return ok;
    end
    if (dec_digit(amp_rel(d, 2))) begin
      ok = 1'b1;
      for (j = 3; j < d; j++) if (!dec_digit(amp_rel(d, j))) ok = 1'b0;
      return ok;
    end
    return 1'b0;
  endfunction

  function void shift_in(logic [7:0] b);
    int i;
    if (consumed < (1 << xwt_pkg::COUNT_BITS_DEF) - 1) consumed++;
    for (i = xwt_pkg::LOOKBACK_DEPTH - 1; i > 0; i--) hist[i] = hist[i-1];
    hist[0] = b;
    if (hist_n < xwt_pkg::LOOKBACK_DEPTH) hist_n++;
  endfunction

  function void push_byte(logic [7:0] b);
    xwt_pkg::res_t r;
    r = '0;
    r.out_byte = b;
    due_results.push_back(r);
  endfunction

  function void push_summary(int cnt, int wl, bit ovf);
    xwt_pkg::res_t r;
    r = '0;
    r.is_word_end    = 1'b1;
    r.consumed_count = cnt[15:0];
    r.word_length    = wl[8:0];
    r.overflow       = ovf;
    due_results.push_back(r);
  endfunction

  function void close_scan();
    push_summary(consumed, tok_len, 1'b0);
    phase = xwt_pkg::PH_IDLE;
  endfunction

  // advance the scan by one accepted byte and queue what it yields
  function void take_byte(logic [7:0] b, logic st, logic en);
    int i;
    bit stop;
    if (st) begin
      phase    = xwt_pkg::PH_SKIP;
      hist_n   = 0;
      tok_len  = 0;
      consumed = 0;
    end
    if (phase == xwt_pkg::PH_IDLE) return;
    if (phase == xwt_pkg::PH_SKIP) begin
      if (b <= 8'd32) begin
        shift_in(b);
        if (en) begin
          push_summary(0, 0, 1'b0);
          phase = xwt_pkg::PH_IDLE;
        end
        return;
      end
      phase = xwt_pkg::PH_WORD;
    end
    stop = (b <= xwt_pkg::CH_SPACE) || (b == xwt_pkg::CH_DEL);
    for (i = 0; i < active_delims(); i++)
      if (b == delim[i]) stop = 1'b1;
    if (stop) begin
      close_scan();
      return;
    end
    if (is_punct(b)) begin
      shift_in(b);
      close_scan();
      return;
    end
    if (b == xwt_pkg::CH_SEMI) begin
      if (entity_before_semi()) begin
        push_byte(xwt_pkg::CH_SEMI);
        tok_len++;
      end
      shift_in(b);
      close_scan();
      return;
    end
    if (tok_len >= max_len) begin
      push_summary(0, tok_len, 1'b1);
      phase = xwt_pkg::PH_IDLE;
      return;
    end
    push_byte(b);
    tok_len++;
    shift_in(b);
    if (en) close_scan();
  endfunction

  function void match_result(xwt_pkg::res_t got);
    xwt_pkg::res_t want;
    if (due_results.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result: byte %0d end %0b count %0d len %0d ovf %0b",
                 got.out_byte, got.is_word_end, got.consumed_count,
                 got.word_length, got.overflow);
      return;
    end
    want = due_results.pop_front();
    if (got.out_byte !== want.out_byte || got.is_word_end !== want.is_word_end ||
        got.consumed_count !== want.consumed_count ||
        got.word_length !== want.word_length || got.overflow !== want.overflow) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: want byte %0d end %0b count %0d len %0d ovf %0b / got %0d %0b %0d %0d %0b",
                 want.out_byte, want.is_word_end, want.consumed_count,
                 want.word_length, want.overflow, got.out_byte, got.is_word_end,
                 got.consumed_count, got.word_length, got.overflow);
    end
  endfunction

  function int pending();
    return due_results.size();
  endfunction
endclass

module xml_word_tokenizer_top_tb;

  logic                 clk;
  logic                 rst_n         = 1'b0;
  logic                 in_valid      = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_data_byte  = 8'd0;
  logic                 in_scan_start = 1'b0;
  logic                 in_data_end   = 1'b0;
  logic                 out_valid;
  logic                 out_stall     = 1'b0;
  logic [7:0]           out_byte;
  logic                 out_is_word_end;
  logic [15:0]          out_consumed_count;
  logic [8:0]           out_word_length;
  logic                 out_overflow;
  logic                 cfg_wr_en     = 1'b0;
  logic [xwt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_wdata     = 8'd0;

  word_tracker sb = new();

  // chance in percent that a side idles in a given cycle
  int idle_pct  = 37;
  int stall_pct = 37;
  int sent      = 0;

  // bytes of the scan being assembled
  logic [7:0] text_q [$];

  xml_word_tokenizer_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_scan_start     (in_scan_start),
    .in_data_end       (in_data_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_is_word_end   (out_is_word_end),
    .out_consumed_count(out_consumed_count),
    .out_word_length   (out_word_length),
    .out_overflow      (out_overflow),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: check each accepted word, then pick the next stall value.
  // Outputs are sampled at the edge, before the block's own updates land.
  always @(posedge clk) begin
    xwt_pkg::res_t got;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      got.out_byte       = out_byte;
      got.is_word_end    = out_is_word_end;
      got.consumed_count = out_consumed_count;
      got.word_length    = out_word_length;
      got.overflow       = out_overflow;
      sb.match_result(got);
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Offer one byte, idling first for a random number of cycles, and hold it
  // until the block takes it. Valid is only lowered on a step that does not
  // raise it again.
  task automatic send_byte(input logic [7:0] b, input logic st, input logic en);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_scan_start <= st;
    in_data_end   <= en;
    do @(posedge clk); while (in_stall);
    sb.take_byte(b, st, en);
    sent++;
  endtask

  // Stop sending and wait until every queued result is out, then give the
  // block time to finish bytes that produce nothing.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [xwt_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // Close any open scan, drain, then rewrite every register.
  task automatic load_settings(input logic [7:0] mx, input logic [2:0] nd,
                               input logic [7:0] da, input logic [7:0] db,
                               input logic [7:0] dc, input logic [7:0] dd);
    if (sb.phase != xwt_pkg::PH_IDLE) send_byte(xwt_pkg::CH_SPACE, 1'b1, 1'b1);
    drain_results();
    cfg_put(xwt_pkg::REG_MAX_WORD_LEN, mx);
    cfg_put(xwt_pkg::REG_DELIM_COUNT, {5'd0, nd});
    cfg_put(xwt_pkg::REG_DELIM_A, da);
    cfg_put(xwt_pkg::REG_DELIM_B, db);
    cfg_put(xwt_pkg::REG_DELIM_C, dc);
    cfg_put(xwt_pkg::REG_DELIM_D, dd);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [7:0] punct_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(33, 126)); while (!sb.is_punct(c));
    return c;
  endfunction

  // A byte that joins a token unless it happens to match a delimiter.
  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    case ($urandom_range(0, 4))
      0, 1: begin
        do c = 8'($urandom_range(0, 255));
        while (c <= xwt_pkg::CH_SPACE || c == xwt_pkg::CH_DEL ||
               c == xwt_pkg::CH_SEMI || sb.is_punct(c));
      end
      2: c = 8'("a" + $urandom_range(0, 25));
      3: c = 8'("0" + $urandom_range(0, 9));
      default: c = ($urandom_range(0, 1) != 0) ? xwt_pkg::CH_AMP : "#";
    endcase
    return c;
  endfunction

  function automatic void push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  // Append a named, numeric or broken entity body (no ';').
  function automatic void add_entity();
    string hx;
    int i;
    hx = "0123456789abcdefABCDEF";
    case ($urandom_range(0, 8))
      0: push_text("&quot");
      1: push_text("&apos");
      2: push_text("&lt");
      3: push_text("&gt");
      4: push_text("&amp");
      5: begin
        push_text("&#x");
        repeat ($urandom_range(0, 4)) text_q.push_back(hx[$urandom_range(0, 21)]);
      end
      6: begin
        push_text("&#");
        repeat ($urandom_range(0, 6)) text_q.push_back(8'("0" + $urandom_range(0, 9)));
      end
      default: begin
        text_q.push_back(xwt_pkg::CH_AMP);
        for (i = $urandom_range(1, 6); i > 0; i--) text_q.push_back(plain_byte());
      end
    endcase
  endfunction

  // Send text_q as one scan; the start flag rides on the first byte.
  task automatic send_queue(input bit end_last);
    int i;
    for (i = 0; i < text_q.size(); i++)
      send_byte(text_q[i], i == 0, end_last && i == text_q.size() - 1);
  endtask

  // One well-formed scan with random content and a random way of ending,
  // followed by a few bytes the block should mostly ignore.
  task automatic run_scan();
    int  n;
    int  i;
    bit  end_last;
    end_last = 1'b0;
    text_q.delete();
    if ($urandom_range(0, 1) != 0)
      repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(0, 32)));
    if ($urandom_range(0, 5) == 0) begin
      // aim at the length limit
      n = int'(sb.max_len) + $urandom_range(0, 2) - 1;
      if (n < 0) n = 0;
      if (n > 40) n = $urandom_range(0, 40);
    end else begin
      n = $urandom_range(0, 8);
    end
    for (i = 0; i < n; i++) text_q.push_back(plain_byte());
    if ($urandom_range(0, 4) < 2) add_entity();
    case ($urandom_range(0, 9))
      0, 1: text_q.push_back(xwt_pkg::CH_SEMI);
      2: text_q.push_back(8'($urandom_range(1, 32)));
      3: text_q.push_back(xwt_pkg::CH_DEL);
      4: text_q.push_back(8'd0);
      5: text_q.push_back(punct_byte());
      6: begin
        if (sb.active_delims() != 0)
          text_q.push_back(sb.delim[$urandom_range(0, sb.active_delims() - 1)]);
        else
          text_q.push_back(xwt_pkg::CH_SEMI);
      end
      7: end_last = 1'b1;
      8: ;  // leave the scan open
      default: text_q.push_back(8'($urandom_range(0, 255)));
    endcase
    if (text_q.size() == 0) text_q.push_back(plain_byte());
    send_queue(end_last);
    repeat ($urandom_range(0, 2))
      send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
  endtask

  // Mostly scans, some raw noise with random flags, until n more bytes went in.
  task automatic random_phase(input int n);
    int stop_at;
    stop_at = sent + n;
    while (sent < stop_at) begin
      if ($urandom_range(0, 9) < 8) run_scan();
      else send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                     $urandom_range(0, 3) == 0);
    end
  endtask

  initial begin
    int i;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, reset settings.
    send_byte("x", 1'b0, 1'b0);                 // no scan open: dropped
    send_byte(xwt_pkg::CH_SPACE, 1'b1, 1'b1);   // data ends while skipping
    send_byte("a", 1'b1, 1'b0);                 // named entity keeps its ';'
    send_byte(xwt_pkg::CH_AMP, 1'b0, 1'b0);
    send_byte("l", 1'b0, 1'b0);
    send_byte("t", 1'b0, 1'b0);
    send_byte(xwt_pkg::CH_SEMI, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b1);               // high byte, data ends in token
    send_byte(8'h00, 1'b1, 1'b0);               // NUL skipped, DEL stops
    send_byte(xwt_pkg::CH_DEL, 1'b0, 1'b0);
    send_byte("!", 1'b1, 1'b0);                 // separator consumed
    send_byte(xwt_pkg::CH_AMP, 1'b1, 1'b0);     // hex entity with no digits
    send_byte("#", 1'b0, 1'b0);
    send_byte("x", 1'b0, 1'b0);
    send_byte(xwt_pkg::CH_SEMI, 1'b0, 1'b0);
    send_byte("q", 1'b1, 1'b0);                 // open scan aborted by a new start
    send_byte("r", 1'b1, 1'b1);

    load_settings(8'd255, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0);

    // Skip run with no idling on either side.
    idle_pct  = 0;
    stall_pct = 0;
    send_byte(xwt_pkg::CH_SPACE, 1'b1, 1'b0);
    repeat (40) send_byte(8'($urandom_range(0, 32)), 1'b0, 1'b0);
    send_byte("o", 1'b0, 1'b0);
    send_byte("k", 1'b0, 1'b0);
    send_byte(xwt_pkg::CH_SPACE, 1'b0, 1'b0);
    idle_pct  = 37;
    stall_pct = 37;

    // Token one byte past the limit.
    text_q.delete();
    for (i = 0; i < 256; i++) text_q.push_back(plain_byte());
    send_queue(1'b0);

    // Token at the limit plus an entity ';' on top.
    text_q.delete();
    for (i = 0; i < 251; i++) text_q.push_back(8'("a" + $urandom_range(0, 25)));
    push_text("&amp");
    text_q.push_back(xwt_pkg::CH_SEMI);
    send_queue(1'b0);

    random_phase(20);

    // Every plain byte overflows; delimiters include NUL and 0xFF.
    load_settings(8'd0, 3'd4, "a", "e", 8'hFF, 8'h00);
    random_phase(20);

    // Count above the register file; '&', '#', 'x' and ';' become delimiters.
    load_settings(8'd5, 3'd7, xwt_pkg::CH_AMP, "#", "x", xwt_pkg::CH_SEMI);
    random_phase(20);

    load_settings(8'd1, 3'd1, "z", 8'h80, "b", "c");
    random_phase(20);

    // Back-to-back stretch on both sides.
    load_settings(8'd12, 3'd2, "m", "0", "t", "p");
    idle_pct  = 0;
    stall_pct = 0;
    random_phase(60);
    idle_pct  = 37;
    stall_pct = 37;

    load_settings(8'd30, 3'd5, "k", 8'hC3, "5", "q");
    random_phase(20);

    load_settings(8'd3, 3'd3, "9", 8'h00, "s", 8'h7E);
    random_phase(20);

    if (sb.phase != xwt_pkg::PH_IDLE) send_byte(xwt_pkg::CH_SPACE, 1'b1, 1'b1);
    drain_results();
    repeat (10) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
